>>> hdl/multi_client_watchdog_supervisor_macros.svh
// Assertion helpers used by the sequencer (mcws_seq)
`ifndef MULTI_CLIENT_WATCHDOG_SUPERVISOR_MACROS_SVH
`define MULTI_CLIENT_WATCHDOG_SUPERVISOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MCWS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MCWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCWS_ASSERT_IMPL(label, ante, cons, msg)
`define MCWS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hdl/mcws_pkg.sv
package mcws_pkg;

    // table size and derived widths
    localparam int MAX_CLIENTS = 8;
    localparam int SLOT_W      = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);

    // field widths
    localparam int CMD_W     = 3;
    localparam int CLIENT_W  = 3;
    localparam int TMO_W     = 16;
    localparam int CD_W      = 17;
    localparam int CMP_W     = (CNT_W > CLIENT_W) ? CNT_W : CLIENT_W;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    localparam logic [TMO_W-1:0] NEAR_LIMIT = TMO_W'(10);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_REGISTER = 3'd1,
        CMD_RESET    = 3'd2,
        CMD_ENABLE   = 3'd3,
        CMD_DISABLE  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD,
        ST_UPD,
        ST_DONE
    } state_t;

    // result of the shared countdown unit
    typedef struct packed {
        logic [CD_W-1:0] value;
        logic            neg;
        logic            near;
    } cnt_res_t;

    // table RAM controls from the sequencer
    typedef struct packed {
        logic [SLOT_W-1:0] raddr;
        logic              cd_we;
        logic              rl_we;
        logic [SLOT_W-1:0] waddr;
        logic [CD_W-1:0]   cd_wdata;
        logic [TMO_W-1:0]  rl_wdata;
    } ram_ctl_t;

endpackage

>>> hdl/mcws_ram.sv
module mcws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                           aclk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hdl/mcws_cnt_unit.sv
module mcws_cnt_unit (
    input  logic [mcws_pkg::CD_W-1:0] cd,
    input  logic                      en,
    output mcws_pkg::cnt_res_t        res
);
    import mcws_pkg::*;

    logic            dec;
    logic [CD_W-1:0] value;

    // decrement an enabled countdown, saturating at -1
    assign dec   = en && !cd[CD_W-1];
    assign value = dec ? (cd - CD_W'(1)) : cd;

    // expiry and near-expiry compares on the updated value
    assign res.value = value;
    assign res.neg   = value[CD_W-1];
    assign res.near  = value[CD_W-1] || (value[TMO_W-1:0] < NEAR_LIMIT);
endmodule

>>> hdl/mcws_seq.sv
`include "multi_client_watchdog_supervisor_macros.svh"

module mcws_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mcws_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mcws_pkg::M_TDATA_W-1:0] m_tdata,
    output mcws_pkg::ram_ctl_t             ctl,
    input  logic [mcws_pkg::TMO_W-1:0]     rl_rdata,
    output logic                           unit_en,
    input  mcws_pkg::cnt_res_t             unit_res
);
    import mcws_pkg::*;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CLIENT_W-1:0]    slot_reg, slot_next;
    logic [TMO_W-1:0]       tmo_reg, tmo_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [MAX_CLIENTS-1:0] en_reg, en_next;
    logic                   exp_reg, exp_next;
    logic                   near_reg, near_next;
    logic                   acc_reg, acc_next;
    logic [CLIENT_W-1:0]    asg_reg, asg_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                   accept;
    logic                   slot_ok;
    logic                   full;
    logic                   idx_last;
    logic                   out_free;
    logic                   kick;
    logic [SLOT_W-1:0]      slot_addr;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign slot_addr = SLOT_W'(slot_reg);
    assign slot_ok   = CMP_W'(slot_reg) < CMP_W'(count_reg);
    assign full      = (count_reg == CNT_W'(MAX_CLIENTS));
    assign idx_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign kick      = (cmd_reg == CMD_TICK) && (count_reg != '0) && !exp_reg;
    assign unit_en   = en_reg[idx_reg];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (cmd_reg)
                    CMD_TICK:  state_next = (count_reg != '0) ? ST_RD : ST_DONE;
                    CMD_RESET: state_next = slot_ok ? ST_RD : ST_DONE;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_RD: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (cmd_reg == CMD_TICK && !idx_last) begin
                    state_next = ST_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        cmd_next      = cmd_reg;
        slot_next     = slot_reg;
        tmo_next      = tmo_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        en_next       = en_reg;
        exp_next      = exp_reg;
        near_next     = near_reg;
        acc_next      = acc_reg;
        asg_next      = asg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        ctl.raddr     = (cmd_reg == CMD_TICK) ? idx_reg : slot_addr;
        ctl.cd_we     = 1'b0;
        ctl.rl_we     = 1'b0;
        ctl.waddr     = slot_addr;
        ctl.cd_wdata  = {1'b0, rl_rdata};
        ctl.rl_wdata  = tmo_reg;

        // output register drains independently
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next  = cmd_t'(s_tdata[CMD_W-1:0]);
                    slot_next = s_tdata[CMD_W +: CLIENT_W];
                    tmo_next  = s_tdata[CMD_W+CLIENT_W +: TMO_W];
                end
            end
            ST_EXEC: begin
                idx_next  = '0;
                exp_next  = 1'b0;
                near_next = 1'b0;
                acc_next  = 1'b1;
                asg_next  = '0;
                case (cmd_reg)
                    CMD_REGISTER: begin
                        if (full) begin
                            acc_next = 1'b0;
                        end else begin
                            ctl.waddr    = SLOT_W'(count_reg);
                            ctl.cd_we    = 1'b1;
                            ctl.rl_we    = 1'b1;
                            ctl.cd_wdata = {1'b0, tmo_reg};
                            en_next[SLOT_W'(count_reg)] = 1'b1;
                            count_next   = count_reg + CNT_W'(1);
                            asg_next     = CLIENT_W'(count_reg);
                        end
                    end
                    CMD_ENABLE: begin
                        if (slot_ok) begin
                            en_next[slot_addr] = 1'b1;
                        end
                    end
                    CMD_DISABLE: begin
                        if (slot_ok) begin
                            en_next[slot_addr] = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            ST_UPD: begin
                ctl.cd_we = 1'b1;
                if (cmd_reg == CMD_TICK) begin
                    // write back one client's countdown and fold its flags
                    ctl.waddr    = idx_reg;
                    ctl.cd_wdata = unit_res.value;
                    exp_next     = exp_reg || unit_res.neg;
                    near_next    = near_reg || unit_res.near;
                    idx_next     = idx_reg + SLOT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({asg_reg, acc_reg, near_reg, exp_reg, kick});
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        slot_reg    <= slot_next;
        tmo_reg     <= tmo_next;
        idx_reg     <= idx_next;
        en_reg      <= en_next;
        exp_reg     <= exp_next;
        near_reg    <= near_next;
        acc_reg     <= acc_next;
        asg_reg     <= asg_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `MCWS_ASSERT_IMPL(a_count_max, 1'b1, count_reg <= CNT_W'(MAX_CLIENTS), "client count overflow")
    `MCWS_ASSERT_IMPL(a_walk_range, state_reg == ST_UPD && cmd_reg == CMD_TICK, CNT_W'(idx_reg) < count_reg, "tick walk past table end")
    `MCWS_ASSERT_NEXT(a_full_hold, state_reg == ST_EXEC && cmd_reg == CMD_REGISTER && full, $stable(count_reg), "refused register changed count")
    `MCWS_ASSERT_IMPL(a_kick_excl, m_tvalid_reg, !(m_tdata_reg[0] && m_tdata_reg[1]), "kick with expired client")
    `MCWS_ASSERT_NEXT(a_count_tick, state_reg != ST_EXEC, $stable(count_reg), "count changed outside exec")
endmodule

>>> hdl/multi_client_watchdog_supervisor.sv
// Steps, request accept to result valid: a tick with N clients registered walks every slot
// through the shared countdown unit, with a read step and an update step per slot; a reset of
// a registered client takes one read and one update step; any other request goes to done.
// A new request is taken only once the last result is loaded; a result left waiting on m_tready
// holds the block in its last step with s_tready low until it is taken.
// Reset (aresetn low, synchronous) empties the table and clears the result valid.
module multi_client_watchdog_supervisor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command[2:0], client[5:3], timeout[21:6], zero pad[23:22]
    input  logic [mcws_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // kick[0], expired[1], near_expiry[2], accepted[3], assigned_slot[6:4], zero pad[7]
    output logic [mcws_pkg::M_TDATA_W-1:0] m_tdata
);
    import mcws_pkg::*;

    ram_ctl_t         ctl;
    logic [CD_W-1:0]  cd_rdata;
    logic [TMO_W-1:0] rl_rdata;
    logic             unit_en;
    cnt_res_t         unit_res;

    // sequencer
    mcws_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctl      (ctl),
        .rl_rdata (rl_rdata),
        .unit_en  (unit_en),
        .unit_res (unit_res)
    );

    // shared countdown and compare unit
    mcws_cnt_unit u_unit (
        .cd  (cd_rdata),
        .en  (unit_en),
        .res (unit_res)
    );

    // countdown table
    mcws_ram #(
        .WIDTH (CD_W),
        .DEPTH (MAX_CLIENTS)
    ) u_cd_ram (
        .aclk  (aclk),
        .we    (ctl.cd_we),
        .waddr (ctl.waddr),
        .wdata (ctl.cd_wdata),
        .raddr (ctl.raddr),
        .rdata (cd_rdata)
    );

    // reload table
    mcws_ram #(
        .WIDTH (TMO_W),
        .DEPTH (MAX_CLIENTS)
    ) u_rl_ram (
        .aclk  (aclk),
        .we    (ctl.rl_we),
        .waddr (ctl.waddr),
        .wdata (ctl.rl_wdata),
        .raddr (ctl.raddr),
        .rdata (rl_rdata)
    );
endmodule
